// ===== hw/rtl/djb2_hash_set_with_purge_defines.svh =====
// Assertion macros for the djb2 hash set with timed purge.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef DJB2_HASH_SET_WITH_PURGE_DEFINES_SVH
`define DJB2_HASH_SET_WITH_PURGE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DHS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dhs: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define DHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dhs: next-cycle check failed");

`endif

// ===== hw/rtl/dhs_pkg.sv =====
// Shared types, codes and constants of the djb2 hash set with timed purge.
// No dependencies.
package dhs_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 64;
  localparam int unsigned HASH_WIDTH_DEF  = 32;

  localparam int unsigned INTERVAL_W = 31;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [INTERVAL_W-1:0] PURGE_RESET_MS = 31'd60000;

  // Register index, taken from paddr bit 2
  localparam logic REG_PURGE_INTERVAL = 1'b0;

  // Command codes
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [7:0]           char_byte;
    logic                 byte_present;
    logic                 end_of_string;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic               is_match;
    logic               was_added;
    logic               store_full;
    logic               purged;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic                  tick;
    logic [ELAPSED_W-1:0]  elapsed;
    logic                  cfg_we;
    logic [INTERVAL_W-1:0] cfg_data;
  } timer_ctrl_t;

endpackage

// ===== hw/rtl/dhs_store.sv =====
// Hash store memory: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module dhs_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/dhs_timer.sv =====
// Purge countdown and the purge interval register.
// Depends on dhs_pkg.
module dhs_timer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dhs_pkg::timer_ctrl_t            ctrl_i,
  output logic                            expired_o,
  output logic [dhs_pkg::INTERVAL_W-1:0]  interval_o
);
  import dhs_pkg::*;

  logic [INTERVAL_W-1:0] interval_q, interval_d;
  logic [INTERVAL_W-1:0] remain_q, remain_d;
  logic [INTERVAL_W-1:0] elapsed_ext;

  assign elapsed_ext = {{(INTERVAL_W-ELAPSED_W){1'b0}}, ctrl_i.elapsed};
  // Remaining time never goes negative, so expiry is remaining <= elapsed
  assign expired_o   = (remain_q <= elapsed_ext);
  assign interval_o  = interval_q;

  always_comb begin
    interval_d = ctrl_i.cfg_we ? ctrl_i.cfg_data : interval_q;
    remain_d   = remain_q;
    if (ctrl_i.tick) begin
      remain_d = expired_o ? interval_q : (remain_q - elapsed_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= PURGE_RESET_MS;
      remain_q   <= PURGE_RESET_MS;
    end else begin
      interval_q <= interval_d;
      remain_q   <= remain_d;
    end
  end

endmodule

// ===== hw/rtl/djb2_hash_set_with_purge.sv =====
// Top level of the djb2 hash set with timed purge.
// Depends on dhs_pkg, dhs_store, dhs_timer and the assertion macro header.
`include "djb2_hash_set_with_purge_defines.svh"

// Usage
//   Input channel (in_valid_i / in_stall_o / in_item_i): one item per transfer,
//   either a string byte under an add or query command, or a time tick.
//   Output channel (out_valid_o / out_stall_i / out_item_o): one result per
//   end-of-string item and per tick; plain byte items give none.
//   A byte item is taken and folds the hash as h*33+byte.
//   A tick's result is registered in the output register as the tick is taken.
//   An end-of-string item starts a search of the store, one entry per cycle
//   through the memory read port. The search ends at a hit or at the last
//   held entry, and its result is registered in the output register as the
//   search ends. No new item is taken while searching.
//   The output register parts the two sides: a new item is taken while a
//   result leaves; a result held by out_stall_i blocks further input.
//   Reset (rst_ni, asynchronous) empties the store by zeroing its count,
//   loads the interval register and countdown with 60000 ms; memory
//   contents are left as they are and never read before written.
//   The APB port holds purge_interval_ms at byte address 0; pready is high.
module djb2_hash_set_with_purge #(
  parameter int unsigned STORE_DEPTH = dhs_pkg::STORE_DEPTH_DEF,
  parameter int unsigned HASH_WIDTH  = dhs_pkg::HASH_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dhs_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dhs_pkg::out_item_t            out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dhs_pkg::PADDR_W-1:0]   paddr,
  input  logic [dhs_pkg::PDATA_W-1:0]   pwdata,
  output logic [dhs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import dhs_pkg::*;

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] USED_MAX = CW'(STORE_DEPTH);

  state_e                state_q, state_d;
  logic [HASH_WIDTH-1:0] hash_q, hash_d;
  logic [1:0]            cnt_q, cnt_d;
  logic [CW-1:0]         used_q, used_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [HASH_WIDTH-1:0] srch_hash_q, srch_hash_d;
  logic                  srch_add_q, srch_add_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic                  in_acc;
  logic                  is_string;
  logic [HASH_WIDTH-1:0] folded;
  logic [1:0]            cnt_new;
  logic [CW-1:0]         nxt_idx;
  logic                  hit;
  logic                  done;
  logic                  result_set;
  logic [CW+COUNT_W-1:0] used_ext;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [HASH_WIDTH-1:0] rd_data;

  logic                  tick_en;
  logic                  expired;
  logic [INTERVAL_W-1:0] interval;
  logic                  cfg_we;
  timer_ctrl_t           timer_ctrl;

  // Hold input while searching or while a stalled result sits in the register
  assign in_stall_o = (state_q != ST_IDLE) | (out_valid_q & out_stall_i);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_string  = (in_item_i.command == CMD_ADD) || (in_item_i.command == CMD_QUERY);

  // djb2 fold: h*33 + byte as shift and add
  assign folded = in_item_i.byte_present
                ? ((hash_q << 5) + hash_q + {{(HASH_WIDTH-8){1'b0}}, in_item_i.char_byte})
                : hash_q;
  // Byte count saturates at two; only "two or more" matters
  assign cnt_new = (in_item_i.byte_present && cnt_q != 2'd2) ? (cnt_q + 2'd1) : cnt_q;

  // Search: idx_q names the entry whose data arrives this cycle
  assign nxt_idx = idx_q + 1'b1;
  assign hit     = (idx_q < used_q) && (rd_data == srch_hash_q);
  assign done    = hit || (nxt_idx >= used_q);
  assign wr_addr = used_q[AW-1:0];

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    idx_d       = idx_q;
    srch_hash_d = srch_hash_q;
    srch_add_d  = srch_add_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_addr     = nxt_idx[AW-1:0];
    wr_en       = 1'b0;
    tick_en     = 1'b0;
    result_set  = 1'b0;

    // Drop the result once its transfer completes
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.command == CMD_TICK) begin
            tick_en     = 1'b1;
            result_set  = 1'b1;
            out_valid_d = 1'b1;
            out_d       = '0;
            out_d.purged = expired;
            if (expired) begin
              used_d = '0;
            end
          end else if (is_string) begin
            if (in_item_i.end_of_string) begin
              // Start the search at entry zero; reset the string state
              hash_d      = '0;
              cnt_d       = 2'd0;
              srch_hash_d = folded;
              srch_add_d  = (in_item_i.command == CMD_ADD) && (cnt_new == 2'd2);
              idx_d       = '0;
              rd_addr     = '0;
              state_d     = ST_SEARCH;
            end else begin
              hash_d = folded;
              cnt_d  = cnt_new;
            end
          end
        end
      end
      ST_SEARCH: begin
        idx_d = nxt_idx;
        if (done) begin
          state_d     = ST_IDLE;
          result_set  = 1'b1;
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.is_match = hit;
          if (srch_add_q && !hit) begin
            if (used_q < USED_MAX) begin
              wr_en           = 1'b1;
              used_d          = used_q + 1'b1;
              out_d.was_added = 1'b1;
            end else begin
              out_d.store_full = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    used_ext = {{COUNT_W{1'b0}}, used_d};
    if (result_set) begin
      out_d.entry_count = used_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hash_q      <= '0;
      cnt_q       <= 2'd0;
      used_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    srch_hash_q <= srch_hash_d;
    srch_add_q  <= srch_add_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  dhs_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (HASH_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (srch_hash_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Configuration: one register, decoded on paddr bit 2
  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_PURGE_INTERVAL);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PURGE_INTERVAL)
                ? {{(PDATA_W-INTERVAL_W){1'b0}}, interval}
                : '0;

  assign timer_ctrl.tick     = tick_en;
  assign timer_ctrl.elapsed  = in_item_i.elapsed_ms;
  assign timer_ctrl.cfg_we   = cfg_we;
  assign timer_ctrl.cfg_data = pwdata[INTERVAL_W-1:0];

  dhs_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (timer_ctrl),
    .expired_o  (expired),
    .interval_o (interval)
  );

  // The output register is always free while a search runs
  `DHS_ASSERT_NOW(a_search_out_free, state_q == ST_SEARCH, !out_valid_q)
  // The entry count never exceeds the store depth
  `DHS_ASSERT_NOW(a_used_bound, 1'b1, used_q <= USED_MAX)
  // A tick always leaves a result in the output register
  `DHS_ASSERT_NEXT(a_tick_result, in_acc && in_item_i.command == CMD_TICK, out_valid_q)
  // An add never both inserts and reports a full store
  `DHS_ASSERT_NOW(a_add_xor_full, out_valid_q, !(out_q.was_added && out_q.store_full))

endmodule

// ===== tb/djb2_hash_set_with_purge_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for djb2_hash_set_with_purge: drives strings, ticks and noise,
// predicts every result in a small tracker class and writes the purge interval over APB.
// Depends on dhs_pkg and the djb2_hash_set_with_purge top level.
module djb2_hash_set_with_purge_test;
  import dhs_pkg::*;

  // Command code that the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] PURGE_INTERVAL_ADDR = {REG_PURGE_INTERVAL, 2'b00};

  // A search over a full store plus the output register, with margin
  localparam int unsigned SETTLE_CYCLES   = 80;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned REPORT_LIMIT    = 60;
  localparam int unsigned POOL_MAX        = 300;

  // Predicts the block from the transfers it accepts and holds the results still owed.
  class hash_set_tracker;
    logic [HASH_WIDTH_DEF-1:0] running_hash;
    int unsigned               byte_count;
    logic [HASH_WIDTH_DEF-1:0] held_hashes [STORE_DEPTH_DEF];
    int unsigned               used_entries;
    longint                    time_left;
    logic [INTERVAL_W-1:0]     purge_interval;
    out_item_t                 pending_results [$];
    int unsigned               failures;

    function new();
      running_hash   = '0;
      byte_count     = 0;
      used_entries   = 0;
      purge_interval = PURGE_RESET_MS;
      time_left      = PURGE_RESET_MS;
      failures       = 0;
    endfunction

    function bit holds(logic [HASH_WIDTH_DEF-1:0] h);
      for (int unsigned k = 0; k < used_entries; k++)
        if (held_hashes[k] == h) return 1'b1;
      return 1'b0;
    endfunction

    // Fold one accepted transfer into the state; return 0 for transfers the block ignores.
    function bit take_item(in_item_t it);
      out_item_t res;
      res = '0;
      if (it.command == CMD_TICK) begin
        time_left = time_left - longint'(it.elapsed_ms);
        if (time_left <= 0) begin
          time_left    = purge_interval;
          used_entries = 0;
          res.purged   = 1'b1;
        end
      end else if (it.command == CMD_ADD || it.command == CMD_QUERY) begin
        if (it.byte_present) begin
          running_hash = running_hash * 32'd33 + 32'(it.char_byte);
          if (byte_count < 2) byte_count++;
        end
        if (!it.end_of_string) return it.byte_present;
        res.is_match = holds(running_hash);
        if (it.command == CMD_ADD && byte_count >= 2 && !res.is_match) begin
          if (used_entries < STORE_DEPTH_DEF) begin
            held_hashes[used_entries] = running_hash;
            used_entries++;
            res.was_added = 1'b1;
          end else begin
            res.store_full = 1'b1;
          end
        end
        running_hash = '0;
        byte_count   = 0;
      end else begin
        return 1'b0;
      end
      res.entry_count = COUNT_W'(used_entries);
      pending_results.insert(pending_results.size(), res);
      return 1'b1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.is_match !== exp_res.is_match || got.was_added !== exp_res.was_added ||
          got.store_full !== exp_res.store_full || got.purged !== exp_res.purged ||
          got.entry_count !== exp_res.entry_count) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: result mismatch: expected match=%0b added=%0b full=%0b",
                   $time, exp_res.is_match, exp_res.was_added, exp_res.store_full,
                   " purged=%0b count=%0d,", exp_res.purged, exp_res.entry_count,
                   " got match=%0b added=%0b full=%0b", got.is_match, got.was_added,
                   got.store_full, " purged=%0b count=%0d", got.purged, got.entry_count);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  hash_set_tracker tracker = new();

  int unsigned effective_items    = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned add_pct            = 55;
  int unsigned hold_off_requests  = 0;
  int unsigned hold_off_served    = 0;
  int unsigned hold_off_left      = 0;
  int unsigned quiet_cycles       = 0;

  // Strings seen before, packed low byte first, so that later strings can hit the store
  bit [39:0]   string_pool [$];
  int unsigned pool_lengths [$];

  djb2_hash_set_with_purge i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: stall at random, or hold off for a long stretch when the stimulus asks,
  // so that the output register stays full and the block has to stall its input.
  always @(negedge clk_i) begin
    if (hold_off_served != hold_off_requests) begin
      hold_off_served = hold_off_requests;
      hold_off_left   = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Check every result transfer against the oldest prediction still owed.
  always @(posedge clk_i) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      tracker.check_result(out_item);
  end

  // Watchdog: give up once nothing has moved on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] cmd, logic [7:0] ch, logic present,
                                         logic ends_here, logic [ELAPSED_W-1:0] ms);
    in_item_t it;
    it.command       = cmd;
    it.char_byte     = ch;
    it.byte_present  = present;
    it.end_of_string = ends_here;
    it.elapsed_ms    = ms;
    return it;
  endfunction

  // Offer one item after a random gap; hold it until the block takes the transfer.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    if (tracker.take_item(it)) effective_items++;
  endtask

  task automatic rest_sender();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write the purge interval (setup then access phase) and read it back.
  task automatic write_purge_interval(logic [INTERVAL_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PURGE_INTERVAL_ADDR;
    pwdata  <= {1'b0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    tracker.purge_interval = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    psel    <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== {1'b0, value}) begin
      tracker.failures++;
      $display("%0t: purge interval read back: expected %0d, got %0d", $time, value, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_tick();
    logic [ELAPSED_W-1:0] ms;
    int unsigned          r;
    r = $urandom_range(99);
    if (r < 50)      ms = 16'($urandom_range(1000));
    else if (r < 70) ms = 16'($urandom_range(20000));
    else             ms = 16'($urandom);
    send_item(make_item(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom), ms));
  endtask

  // Transfers the block drops: the unused command, or a byte item with no byte and no end.
  task automatic send_noise();
    if ($urandom_range(1) == 1)
      send_item(make_item(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom)));
    else
      send_item(make_item(($urandom_range(1) == 1) ? CMD_ADD : CMD_QUERY, 8'($urandom),
                          1'b0, 1'b0, 16'($urandom)));
  endtask

  task automatic send_random_string();
    bit [39:0]   chars;
    int unsigned len;
    int unsigned r;
    int unsigned pick;
    logic [1:0]  end_cmd;
    logic [1:0]  cmd;
    bit          bare_end;
    bit          ends_here;
    end_cmd = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_QUERY;
    if (string_pool.size() > 0 && $urandom_range(99) < 25) begin
      pick  = $urandom_range(string_pool.size() - 1);
      chars = string_pool[pick];
      len   = pool_lengths[pick];
    end else begin
      r = $urandom_range(99);
      if (r < 4)       len = 0;
      else if (r < 12) len = 1;
      else if (r < 55) len = 2;
      else if (r < 80) len = 3;
      else if (r < 92) len = 4;
      else             len = 5;
      chars = {8'($urandom), $urandom};
      // Zero bytes are real characters here: fold them now and then
      if ($urandom_range(9) == 0) chars[8 * $urandom_range(4) +: 8] = 8'h00;
      if (len >= 2 && string_pool.size() < POOL_MAX) begin
        string_pool.insert(string_pool.size(), chars);
        pool_lengths.insert(pool_lengths.size(), len);
      end
    end
    bare_end = (len == 0) || ($urandom_range(99) < 15);
    for (int unsigned i = 0; i < len; i++) begin
      ends_here = (i == len - 1) && !bare_end;
      // Only the end item's command decides; earlier bytes may carry the other one
      if (!ends_here && $urandom_range(99) < 10)
        cmd = (end_cmd == CMD_ADD) ? CMD_QUERY : CMD_ADD;
      else
        cmd = end_cmd;
      send_item(make_item(cmd, chars[8 * i +: 8], 1'b1, ends_here, 16'($urandom)));
      if (!ends_here && $urandom_range(99) < 5) begin
        if ($urandom_range(1) == 1) send_random_tick();
        else send_noise();
      end
    end
    if (bare_end)
      send_item(make_item(end_cmd, 8'($urandom), 1'b0, 1'b1, 16'($urandom)));
  endtask

  // Directed opening, under the reset interval of 60000 ms.
  task automatic run_directed();
    // two-byte add inserts, a query of it hits, a repeat add only reports the hit
    send_item(make_item(CMD_ADD, 8'h61, 1'b1, 1'b0, 16'h0000));
    send_item(make_item(CMD_ADD, 8'h62, 1'b1, 1'b1, 16'h0000));
    send_item(make_item(CMD_QUERY, 8'h61, 1'b1, 1'b0, 16'h0000));
    send_item(make_item(CMD_QUERY, 8'h62, 1'b1, 1'b1, 16'h0000));
    send_item(make_item(CMD_ADD, 8'h61, 1'b1, 1'b0, 16'h0000));
    send_item(make_item(CMD_ADD, 8'h62, 1'b1, 1'b1, 16'h0000));
    // one-byte add never inserts
    send_item(make_item(CMD_ADD, 8'hFF, 1'b1, 1'b1, 16'hFFFF));
    // empty string searches hash zero, then two zero bytes insert hash zero
    send_item(make_item(CMD_QUERY, 8'h00, 1'b0, 1'b1, 16'h0000));
    send_item(make_item(CMD_ADD, 8'h00, 1'b1, 1'b0, 16'h0000));
    send_item(make_item(CMD_ADD, 8'h00, 1'b1, 1'b1, 16'h0000));
    send_item(make_item(CMD_QUERY, 8'h00, 1'b0, 1'b1, 16'h0000));
    // dropped items: no byte and no end, and the unused command
    send_item(make_item(CMD_ADD, 8'h55, 1'b0, 1'b0, 16'h0000));
    send_item(make_item(CMD_UNUSED, 8'hAA, 1'b1, 1'b1, 16'hFFFF));
    // tick with nothing elapsed
    send_item(make_item(CMD_TICK, 8'h00, 1'b0, 1'b0, 16'h0000));
    // mixed commands with a tick inside the string; the end item's add wins
    send_item(make_item(CMD_QUERY, 8'h63, 1'b1, 1'b0, 16'h0000));
    send_item(make_item(CMD_TICK, 8'hFF, 1'b1, 1'b1, 16'd5));
    send_item(make_item(CMD_ADD, 8'h64, 1'b1, 1'b1, 16'h0000));
    // string closed by an end item that carries no byte
    send_item(make_item(CMD_ADD, 8'hFF, 1'b1, 1'b0, 16'h0000));
    send_item(make_item(CMD_ADD, 8'h80, 1'b1, 1'b0, 16'h0000));
    send_item(make_item(CMD_ADD, 8'h7F, 1'b0, 1'b1, 16'h0000));
    // largest tick expires the countdown and clears the store
    send_item(make_item(CMD_TICK, 8'h00, 1'b0, 1'b0, 16'hFFFF));
    send_item(make_item(CMD_QUERY, 8'h61, 1'b1, 1'b0, 16'h0000));
    send_item(make_item(CMD_QUERY, 8'h62, 1'b1, 1'b1, 16'h0000));
  endtask

  initial begin
    logic [INTERVAL_W-1:0] interval;
    int unsigned           target;
    int unsigned           halfway;
    int unsigned           r;
    bit                    paused;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    run_directed();

    for (int p = 0; p < 8; p++) begin
      // Keep register writes to an idle block: drain results, then let the block settle
      rest_sender();
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clk_i);

      // The interval only takes effect at the next reload, so the long ones come last;
      // they let the store fill up and refuse inserts.
      case (p)
        0: interval = 31'd1;
        1: interval = 31'd3000;
        2: interval = 31'd1;
        3: interval = 31'($urandom_range(90000, 20000));
        4: interval = 31'd150000;
        5: interval = 31'd500000;
        6: interval = 31'd2000000;
        default: interval = 31'h7FFF_FFFF;
      endcase
      write_purge_interval(interval);

      case (p % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 68;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 68;
        end
        default: begin
          sender_idle_pct    = 7;
          receiver_stall_pct = 7;
        end
      endcase
      add_pct = (p >= 6) ? 85 : 55;

      // Long receiver hold-off while the sender keeps offering
      if (p == 0 || p == 7) hold_off_requests++;

      target  = effective_items + ((p == 7) ? 240 : 130);
      halfway = effective_items + 65;
      paused  = 1'b0;
      while (effective_items < target) begin
        // Once, let the sender wait for every result still owed
        if (p == 3 && !paused && effective_items >= halfway) begin
          rest_sender();
          wait_results_drained();
          paused = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 7)       send_random_tick();
        else if (r < 11) send_noise();
        else             send_random_string();
      end
    end

    rest_sender();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dhs_pkg.sv
hw/rtl/dhs_store.sv
hw/rtl/dhs_timer.sv
hw/rtl/djb2_hash_set_with_purge.sv
tb/djb2_hash_set_with_purge_test.sv
